[src/rge_pkg.sv]
// Shared types and constants of the room group exclusion arbiter.
package rge_pkg;

    localparam int ROOMS_DEF       = 8;
    localparam int TICKET_BITS_DEF = 16;

    localparam logic [1:0] FUNC_ENTER  = 2'd0;
    localparam logic [1:0] FUNC_EXIT   = 2'd1;
    localparam logic [1:0] FUNC_CHANGE = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] room;
    } t_req;

    typedef struct packed {
        logic [15:0] ticket;
        logic        granted_now;
        logic        last_out;
        logic        switched;
        logic        open_valid;
        logic [2:0]  open_room;
        logic [15:0] admitted_upto;
        logic        error;
    } t_rsp;

    // Broadcast from the controller to every room cell.
    typedef struct packed {
        logic inc_arr;   // target room takes one arrival
        logic admit;     // target room admits up to its arrivals
        logic inc_exit;  // open room counts one exit
        logic seed;      // search token placed on the seed cell
        logic pass;      // token moves on to the next cell
    } t_cell_cmd;

endpackage

[src/rge_stream_if.sv]
// Valid/ready stream interface carrying one payload per transfer.
interface rge_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/rge_cell.sv]
// One room cell: arrival, admitted and exit counters plus the search token stage.
module rge_cell #(
    parameter int TICKET_BITS = rge_pkg::TICKET_BITS_DEF,
    parameter int IDX_W       = 3,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rge_pkg::t_cell_cmd     i_cmd,
    input  logic [IDX_W-1:0]       i_tgt_idx,
    input  logic [IDX_W-1:0]       i_open_idx,
    input  logic [IDX_W-1:0]       i_seed_idx,
    input  logic                   i_tok,
    output logic [TICKET_BITS-1:0] o_arr,
    output logic [TICKET_BITS-1:0] o_adm,
    output logic [TICKET_BITS-1:0] o_ext,
    output logic                   o_tok,
    output logic                   o_found
);
    import rge_pkg::*;

    logic [TICKET_BITS-1:0] r_arr;
    logic [TICKET_BITS-1:0] r_adm;
    logic [TICKET_BITS-1:0] r_ext;
    logic                   r_tok;
    logic [TICKET_BITS-1:0] arr_inc;
    logic [TICKET_BITS-1:0] n_arr;
    logic [TICKET_BITS-1:0] diff;
    logic                   pending;
    logic                   hit_tgt;
    logic                   hit_open;
    logic                   hit_seed;

    assign hit_tgt  = (i_tgt_idx  == IDX_W'(IDX));
    assign hit_open = (i_open_idx == IDX_W'(IDX));
    assign hit_seed = (i_seed_idx == IDX_W'(IDX));

    assign arr_inc = r_arr + TICKET_BITS'(1);
    assign n_arr   = (i_cmd.inc_arr && hit_tgt) ? arr_inc : r_arr;
    assign diff    = r_arr - r_adm;
    assign pending = (diff != '0) && !diff[TICKET_BITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arr <= '0;
            r_adm <= '0;
            r_ext <= '0;
            r_tok <= 1'b0;
        end else begin
            r_arr <= n_arr;
            if (i_cmd.admit && hit_tgt) begin
                r_adm <= n_arr;
            end else if (r_tok && pending) begin
                r_adm <= r_arr;
            end
            if (i_cmd.inc_exit && hit_open) begin
                r_ext <= r_ext + TICKET_BITS'(1);
            end
            r_tok <= (i_cmd.seed && hit_seed) || (i_cmd.pass && i_tok);
        end
    end

    assign o_arr   = r_arr;
    assign o_adm   = r_adm;
    assign o_ext   = r_ext;
    assign o_tok   = r_tok && !pending;
    assign o_found = r_tok && pending;
endmodule

[src/room_group_exclusion_arbiter.sv]
// Group mutual exclusion arbiter: controller, ring of room cells, result register.
//
// Requests arrive on i_req (func, room) and one result per request leaves on
// o_rsp; both are valid/ready channels, a transfer taking place when valid and
// ready are high at a rising edge. One request is handled at a time.
// Enter, and change with no room open: S_ENTER, then S_FINISH. Exit or
// change on an open room: S_ENTER, S_EXIT, S_FINISH, and S_SEARCH before
// S_FINISH when the last user leaves: the search token walks the ring of
// room cells one cell per cycle until a room with pending arrivals is found.
// The result sits in an output register; a new request is taken while it
// waits. When the receiver stalls, the next request is worked up to its
// final step and then held until the output register frees.
// Reset (i_rst_n low, synchronous) clears all counters, closes every room
// and empties the output register.
module room_group_exclusion_arbiter #(
    parameter int ROOMS       = rge_pkg::ROOMS_DEF,
    parameter int TICKET_BITS = rge_pkg::TICKET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rge_stream_if.sink   i_req,
    rge_stream_if.source o_rsp
);
    import rge_pkg::*;

    localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROOMS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENTER,
        S_EXIT,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [1:0]             r_func;
    logic [2:0]             r_room;
    logic                   r_open;
    logic [IDX_W-1:0]       r_open_idx;
    logic [TICKET_BITS-1:0] r_ticket;
    logic                   r_last;
    logic                   r_sw;
    logic                   r_err;
    logic [IDX_W-1:0]       r_cnt;
    logic                   r_out_valid;
    t_rsp                   r_out;

    t_cell_cmd              cmd;
    logic [IDX_W-1:0]       tgt_idx;
    logic [IDX_W-1:0]       seed_idx;
    logic [TICKET_BITS-1:0] c_arr [ROOMS];
    logic [TICKET_BITS-1:0] c_adm [ROOMS];
    logic [TICKET_BITS-1:0] c_ext [ROOMS];
    logic [ROOMS-1:0]       c_tok;
    logic [ROOMS-1:0]       c_found;
    logic [IDX_W-1:0]       found_idx;
    logic                   room_ok;
    logic                   is_enter;
    logic                   is_exit;
    logic                   is_change;
    logic [TICKET_BITS-1:0] tgt_arr;
    logic [TICKET_BITS-1:0] tgt_adm;
    logic [TICKET_BITS-1:0] open_adm;
    logic [TICKET_BITS-1:0] open_ext;
    logic [TICKET_BITS-1:0] grant_diff;
    logic                   granted;
    logic                   is_last;
    logic                   out_free;

    assign tgt_idx   = IDX_W'(r_room);
    assign room_ok   = (32'(r_room) < 32'(ROOMS));
    assign is_enter  = (r_func == FUNC_ENTER);
    assign is_exit   = (r_func == FUNC_EXIT);
    assign is_change = (r_func == FUNC_CHANGE);
    assign seed_idx  = (r_open_idx == LAST_IDX) ? '0 : r_open_idx + IDX_W'(1);

    assign tgt_arr  = c_arr[tgt_idx];
    assign tgt_adm  = c_adm[tgt_idx];
    assign open_adm = c_adm[r_open_idx];
    assign open_ext = c_ext[r_open_idx];

    assign is_last    = ((open_ext + TICKET_BITS'(1)) == open_adm);
    assign grant_diff = tgt_adm - r_ticket;
    assign granted    = (is_enter || is_change) && room_ok && r_open &&
                        (r_open_idx == tgt_idx) && !grant_diff[TICKET_BITS-1];
    assign out_free   = !r_out_valid || o_rsp.ready;

    always_comb begin
        found_idx = '0;
        for (int i = 0; i < ROOMS; i++) begin
            if (c_found[i]) begin
                found_idx = found_idx | IDX_W'(i);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < ROOMS; g++) begin : g_cell
            rge_cell #(
                .TICKET_BITS (TICKET_BITS),
                .IDX_W       (IDX_W),
                .IDX         (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (cmd),
                .i_tgt_idx  (tgt_idx),
                .i_open_idx (r_open_idx),
                .i_seed_idx (seed_idx),
                .i_tok      (c_tok[(g + ROOMS - 1) % ROOMS]),
                .o_arr      (c_arr[g]),
                .o_adm      (c_adm[g]),
                .o_ext      (c_ext[g]),
                .o_tok      (c_tok[g]),
                .o_found    (c_found[g])
            );
        end
    endgenerate

    always_comb begin
        cmd = '0;
        unique case (r_state)
            S_ENTER: begin
                cmd.inc_arr = (is_enter || is_change) && room_ok;
                cmd.admit   = (is_enter || is_change) && room_ok && !r_open;
            end
            S_EXIT: begin
                cmd.inc_exit = 1'b1;
                cmd.seed     = is_last;
            end
            S_SEARCH: begin
                cmd.pass = !(|c_found) && (r_cnt != LAST_IDX);
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= 1'b0;
            r_open_idx  <= '0;
            r_out_valid <= 1'b0;
            r_func      <= '0;
            r_room      <= '0;
            r_ticket    <= '0;
            r_last      <= 1'b0;
            r_sw        <= 1'b0;
            r_err       <= 1'b0;
            r_cnt       <= '0;
            r_out       <= '0;
        end else begin
            priority if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func   <= i_req.data.func;
                        r_room   <= i_req.data.room;
                        r_ticket <= '0;
                        r_last   <= 1'b0;
                        r_sw     <= 1'b0;
                        r_err    <= 1'b0;
                        r_state  <= S_ENTER;
                    end
                end
                S_ENTER: begin
                    if ((is_enter || is_change) && room_ok) begin
                        r_ticket <= tgt_arr + TICKET_BITS'(1);
                    end
                    if ((is_enter || is_change) && room_ok && !r_open) begin
                        r_open     <= 1'b1;
                        r_open_idx <= tgt_idx;
                        r_sw       <= 1'b1;
                    end
                    if ((is_exit || is_change) && !r_open) begin
                        r_err <= 1'b1;
                    end
                    if ((is_exit || is_change) && r_open) begin
                        r_state <= S_EXIT;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_EXIT: begin
                    r_cnt <= '0;
                    if (is_last) begin
                        r_last  <= 1'b1;
                        r_sw    <= 1'b1;
                        r_state <= S_SEARCH;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_SEARCH: begin
                    priority if (|c_found) begin
                        r_open_idx <= found_idx;
                        r_state    <= S_FINISH;
                    end else if (r_cnt == LAST_IDX) begin
                        r_open     <= 1'b0;
                        r_open_idx <= '0;
                        r_state    <= S_FINISH;
                    end else begin
                        r_cnt <= r_cnt + IDX_W'(1);
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out.ticket        <= 16'(r_ticket);
                        r_out.granted_now   <= granted;
                        r_out.last_out      <= r_last;
                        r_out.switched      <= r_sw;
                        r_out.open_valid    <= r_open;
                        r_out.open_room     <= r_open ? 3'(r_open_idx) : 3'd0;
                        r_out.admitted_upto <= r_open ? 16'(open_adm) : 16'd0;
                        r_out.error         <= r_err;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
endmodule
